### rtl/core/sdbgc_pkg.sv
package sdbgc_pkg;

	localparam int RING_FRAMES   = 16384;
	localparam int CHANNEL_COUNT = 2;

	localparam int SAMPLE_W = 32;
	localparam int STATE_W  = 48;
	localparam int FRAME_W  = 14;
	localparam int DB_W     = 6;
	localparam int GAIN_W   = 23;
	localparam int MUL_A_W  = 48;
	localparam int MUL_B_W  = 24;
	localparam int PROD_W   = 64;
	localparam int YC_W     = 34;

	localparam int GAIN_ENTRIES  = 41;
	localparam int GAIN_MAX_DB   = 40;
	localparam int GAIN_RESET_DB = 30;

	localparam logic [MUL_B_W-1:0] POLE_Q16 = 24'd64764;

	localparam longint unsigned LOG_STEP_Q24 = 64'd2786635;
	localparam longint unsigned POLY_C1      = 64'd11629080;
	localparam longint unsigned POLY_C2      = 64'd4028876;
	localparam longint unsigned POLY_C3      = 64'd936642;

	typedef logic [GAIN_W-1:0] gain_tab_t [GAIN_ENTRIES];

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_GAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic sum;
		logic gain;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic                       op;
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic [FRAME_W-1:0]         frame_index;
		logic                       block_first;
		logic                       block_last;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
	} out_word_t;

	// linear gain, Q7.16, from a cubic exp2 fit
	function automatic gain_tab_t build_gain_table();
		gain_tab_t         tab;
		longint unsigned   t;
		longint unsigned   f;
		longint unsigned   p;
		int                xi;
		for (int db = 0; db < GAIN_ENTRIES; db++) begin
			t  = longint'(db) * LOG_STEP_Q24;
			xi = int'(t >> 24);
			f  = t & 64'hFF_FFFF;
			p  = POLY_C2 + ((f * POLY_C3) >> 24);
			p  = POLY_C1 + ((f * p) >> 24);
			p  = 64'd16777216 + ((f * p) >> 24);
			tab[db] = GAIN_W'(((p << xi) + 64'd128) >> 8);
		end
		return tab;
	endfunction

	localparam gain_tab_t GAIN_TABLE = build_gain_table();

endpackage

### rtl/core/stereo_dc_block_gain_clip.sv
// Stereo DC blocker with gain and clip. For each processed word the accept
// cycle runs the pole multiply, then the filter sum, the gain multiply and
// the output load follow; each lane reuses one 48x24 multiplier for both
// products. A start word (op = 1) produces no output. The output register
// frees the input side, but the last step waits while a previous result is
// still stalled. Gain: 0..40 dB, larger values act as 40, reset gain 30 dB.
// Write it through cfg_wr_en/cfg_wr_data only while idle; the block won't check.
module stereo_dc_block_gain_clip #(
	parameter int CHANNEL_COUNT = sdbgc_pkg::CHANNEL_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sdbgc_pkg::in_word_t         in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sdbgc_pkg::out_word_t        out_word,
	input  logic                        cfg_wr_en,
	input  logic [sdbgc_pkg::DB_W-1:0]  cfg_wr_data
);

	sdbgc_pkg::cmd_t cmd;

	sdbgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_word.op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sdbgc_dp #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_word     (in_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_word    (out_word)
	);

endmodule

### rtl/core/sdbgc_ctrl.sv
module sdbgc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sdbgc_pkg::cmd_t   cmd
);

	sdbgc_pkg::state_t state_q;
	sdbgc_pkg::state_t state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdbgc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			sdbgc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_op) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = sdbgc_pkg::ST_SUM;
					end
				end
			end
			sdbgc_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = sdbgc_pkg::ST_GAIN;
			end
			sdbgc_pkg::ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = sdbgc_pkg::ST_DONE;
			end
			sdbgc_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.done = 1'b1;
					state_d  = sdbgc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdbgc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/sdbgc_dp.sv
module sdbgc_dp #(
	parameter int CHANNEL_COUNT = sdbgc_pkg::CHANNEL_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sdbgc_pkg::cmd_t                  cmd,
	input  sdbgc_pkg::in_word_t              in_word,
	input  logic                             cfg_wr_en,
	input  logic [sdbgc_pkg::DB_W-1:0]       cfg_wr_data,
	output sdbgc_pkg::out_word_t             out_word
);

	localparam int LANES = (CHANNEL_COUNT < 2) ? CHANNEL_COUNT : 2;
	localparam int SW    = sdbgc_pkg::SAMPLE_W;
	localparam int YW    = sdbgc_pkg::STATE_W;
	localparam int PW    = sdbgc_pkg::PROD_W;
	localparam int CW    = sdbgc_pkg::YC_W;
	localparam int FW    = sdbgc_pkg::FRAME_W;
	localparam int AW    = sdbgc_pkg::MUL_A_W;
	localparam int BW    = sdbgc_pkg::MUL_B_W;

	localparam logic signed [YW+1:0] Y_MAX  = (YW+2)'((64'sd1 <<< (YW - 1)) - 64'sd1);
	localparam logic signed [YW+1:0] Y_MIN  = (YW+2)'(-(64'sd1 <<< (YW - 1)));
	localparam logic signed [YW-1:0] YC_MAX = YW'(64'sd4294967296);
	localparam logic signed [YW-1:0] YC_MIN = YW'(-64'sd4294967296);
	localparam logic signed [PW-1:0] V_MAX  = PW'(64'sd1073741824);
	localparam logic signed [PW-1:0] V_MIN  = PW'(-64'sd1073741824);

	// gain register holds the looked-up linear gain
	logic [sdbgc_pkg::GAIN_W-1:0] gain_q;
	logic [sdbgc_pkg::DB_W-1:0]   db_sat;

	assign db_sat = (cfg_wr_data > sdbgc_pkg::DB_W'(sdbgc_pkg::GAIN_MAX_DB)) ?
		sdbgc_pkg::DB_W'(sdbgc_pkg::GAIN_MAX_DB) : cfg_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= sdbgc_pkg::GAIN_TABLE[sdbgc_pkg::GAIN_RESET_DB];
		end else if (cfg_wr_en) begin
			gain_q <= sdbgc_pkg::GAIN_TABLE[db_sat];
		end
	end

	// request tracking
	logic [FW-1:0] expected_q;
	logic          seed_q;
	logic          contig_q;
	logic [FW-1:0] frame_s1;
	logic          last_s1;
	logic [FW:0]   next_frame;

	assign next_frame = (FW+1)'(frame_s1) + (FW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			seed_q     <= 1'b1;
			contig_q   <= 1'b0;
		end else if (cmd.clear) begin
			seed_q   <= 1'b1;
			contig_q <= 1'b0;
		end else if (cmd.load && in_word.block_first) begin
			if (seed_q) begin
				expected_q <= in_word.frame_index;
				seed_q     <= 1'b0;
				contig_q   <= 1'b1;
			end else begin
				contig_q <= (in_word.frame_index == expected_q);
			end
		end else if (cmd.done && last_s1) begin
			if (contig_q) begin
				expected_q <= FW'(next_frame % sdbgc_pkg::RING_FRAMES);
			end
			contig_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_s1 <= in_word.frame_index;
			last_s1  <= in_word.block_last;
		end
	end

	logic signed [SW-1:0] samp     [LANES];
	logic signed [SW-1:0] lane_res [LANES];

	assign samp[0] = in_word.sample_left;

	if (LANES > 1) begin : g_right
		assign samp[LANES-1] = in_word.sample_right;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [SW-1:0]   sv_in_q;
		logic signed [YW-1:0]   sv_out_q;
		logic signed [SW-1:0]   wk_in_q;
		logic signed [YW-1:0]   wk_out_q;
		logic signed [SW-1:0]   x_s1;
		logic signed [PW-1:0]   prod_q;
		logic signed [CW-1:0]   yc_q;
		logic signed [YW-1:0]   y1_src;
		logic signed [AW-1:0]   mul_a;
		logic signed [BW-1:0]   mul_b;
		logic signed [AW+BW-1:0] mul_p;
		logic signed [PW-1:0]   r_full;
		logic signed [YW+1:0]   sum;
		logic signed [YW-1:0]   y;
		logic signed [YW-1:0]   yc;
		logic signed [PW-1:0]   v_full;
		logic signed [PW-1:0]   v_clip;

		assign y1_src = in_word.block_first ? sv_out_q : wk_out_q;
		assign mul_a  = cmd.load ? AW'(y1_src) : AW'(yc_q);
		assign mul_b  = cmd.load ? sdbgc_pkg::POLE_Q16 : BW'(gain_q);
		assign mul_p  = mul_a * mul_b;

		assign r_full = (prod_q + PW'(64'sd32768)) >>> 16;
		assign sum    = (YW+2)'($signed(r_full[YW-1:0])) + (YW+2)'(x_s1) - (YW+2)'(wk_in_q);
		assign y      = (sum > Y_MAX) ? Y_MAX[YW-1:0] :
		                (sum < Y_MIN) ? Y_MIN[YW-1:0] : sum[YW-1:0];
		assign yc     = (y > YC_MAX) ? YC_MAX : (y < YC_MIN) ? YC_MIN : y;

		assign v_full = (prod_q + PW'(64'sd65536)) >>> 17;
		assign v_clip = (v_full > V_MAX) ? V_MAX : (v_full < V_MIN) ? V_MIN : v_full;

		assign lane_res[l] = v_clip[SW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_in_q  <= '0;
				sv_out_q <= '0;
				wk_in_q  <= '0;
				wk_out_q <= '0;
			end else if (cmd.clear) begin
				sv_in_q  <= '0;
				sv_out_q <= '0;
				wk_in_q  <= '0;
				wk_out_q <= '0;
			end else if (cmd.load && in_word.block_first) begin
				wk_in_q  <= sv_in_q;
				wk_out_q <= sv_out_q;
			end else if (cmd.sum) begin
				wk_in_q  <= x_s1;
				wk_out_q <= y;
			end else if (cmd.done && last_s1 && contig_q) begin
				sv_in_q  <= wk_in_q;
				sv_out_q <= wk_out_q;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.load) begin
				x_s1 <= samp[l];
			end
			if (cmd.load || cmd.gain) begin
				prod_q <= mul_p[PW-1:0];
			end
			if (cmd.sum) begin
				yc_q <= yc[CW-1:0];
			end
		end
	end

	sdbgc_pkg::out_word_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			out_q.out_left  <= lane_res[0];
			out_q.out_right <= (LANES > 1) ? lane_res[LANES-1] : '0;
		end
	end

	assign out_word = out_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sdbgc_pkg::*;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_START = 1'b1
	} op_e;

	localparam longint          POLE_R   = 64764;
	localparam longint unsigned LOG_STEP = 2786635;
	localparam longint unsigned C1       = 11629080;
	localparam longint unsigned C2       = 4028876;
	localparam longint unsigned C3       = 936642;
	localparam int unsigned     MAX_DB   = 40;
	localparam longint          Y_HI     = 64'sh7FFF_FFFF_FFFF;
	localparam longint          Y_LO     = -Y_HI - 1;
	localparam longint          YC_LIM   = 64'sd4294967296;
	localparam longint          OUT_LIM  = 64'sd1073741824;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

	localparam int SEG_ITEMS    = 142;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 400;

	class stereo_filter_model;
		logic [DB_W-1:0]            gain_db;
		logic signed [SAMPLE_W-1:0] saved_in[2];
		logic signed [SAMPLE_W-1:0] work_in[2];
		longint                     saved_out[2];
		longint                     work_out[2];
		logic [FRAME_W-1:0]         expected_frame;
		bit                         seed_pending;
		bit                         contiguous;
		out_word_t                  pending_outputs[$];
		int                         mismatches;

		function new();
			gain_db = DB_W'(GAIN_RESET_DB);
			clear_filter();
			expected_frame = '0;
			seed_pending = 1'b1;
			contiguous = 1'b0;
			mismatches = 0;
		endfunction

		function void clear_filter();
			for (int ch = 0; ch < 2; ch++) begin
				saved_in[ch] = '0;
				work_in[ch] = '0;
				saved_out[ch] = 0;
				work_out[ch] = 0;
			end
		endfunction

		// Q7.16 linear gain from the cubic exp2 fit
		function longint linear_gain();
			longint unsigned t, f, p;
			int unsigned db, xi;
			db = (gain_db > MAX_DB) ? MAX_DB : gain_db;
			t = longint'(db) * LOG_STEP;
			xi = 32'(t >> 24);
			f = t & 64'hFF_FFFF;
			p = C2 + ((f * C3) >> 24);
			p = C1 + ((f * p) >> 24);
			p = 64'd16777216 + ((f * p) >> 24);
			return longint'(((p << xi) + 64'd128) >> 8);
		endfunction

		function logic [SAMPLE_W-1:0] run_lane(int ch, logic signed [SAMPLE_W-1:0] x, longint g);
			longint y, yc, v;
			y = longint'(x) - longint'(work_in[ch]) + ((work_out[ch] * POLE_R + 64'sd32768) >>> 16);
			if (y > Y_HI)
				y = Y_HI;
			else if (y < Y_LO)
				y = Y_LO;
			work_in[ch] = x;
			work_out[ch] = y;
			yc = (y > YC_LIM) ? YC_LIM : ((y < -YC_LIM) ? -YC_LIM : y);
			v = (yc * g + 64'sd65536) >>> 17;
			if (v > OUT_LIM)
				v = OUT_LIM;
			else if (v < -OUT_LIM)
				v = -OUT_LIM;
			return v[SAMPLE_W-1:0];
		endfunction

		function void accept_frame(in_word_t w);
			out_word_t res;
			longint g;
			if (w.op == OP_START) begin
				clear_filter();
				seed_pending = 1'b1;
				contiguous = 1'b0;
				return;
			end
			if (w.block_first) begin
				if (seed_pending) begin
					expected_frame = w.frame_index;
					seed_pending = 1'b0;
				end
				contiguous = (w.frame_index == expected_frame);
				work_in = saved_in;
				work_out = saved_out;
			end
			g = linear_gain();
			res.out_left = run_lane(0, w.sample_left, g);
			res.out_right = (CHANNEL_COUNT > 1) ? run_lane(1, w.sample_right, g) : '0;
			if (w.block_last) begin
				if (contiguous) begin
					saved_in = work_in;
					saved_out = work_out;
					expected_frame = w.frame_index + 1'b1;
				end
				contiguous = 1'b0;
			end
			pending_outputs.push_back(res);
		endfunction

		function void compare_output(out_word_t act);
			out_word_t ref_w;
			if (pending_outputs.size() == 0) begin
				$error("output word %h with none expected", act);
				mismatches++;
				return;
			end
			ref_w = pending_outputs.pop_front();
			if (act.out_left !== ref_w.out_left) begin
				$error("out_left: expected %0d, actual %0d", ref_w.out_left, act.out_left);
				mismatches++;
			end
			if (act.out_right !== ref_w.out_right) begin
				$error("out_right: expected %0d, actual %0d", ref_w.out_right, act.out_right);
				mismatches++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	in_word_t        in_word = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	out_word_t       out_word;
	logic            cfg_wr_en = 1'b0;
	logic [DB_W-1:0] cfg_wr_data = '0;

	int send_idle_pct = 37;
	int recv_stall_pct = 68;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int items_sent = 0;

	logic [FRAME_W-1:0] ring_pos = '0;
	bit                 need_seed = 1'b1;
	bit                 open_aligned = 1'b0;

	stereo_filter_model filt_model = new();

	stereo_dc_block_gain_clip i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			filt_model.accept_frame(in_word);
		if (out_valid && !out_stall)
			filt_model.compare_output(out_word);
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return $signed($urandom());
			default: return $signed($urandom()) >>> $urandom_range(31);
		endcase
	endfunction

	function automatic in_word_t make_frame(logic [FRAME_W-1:0] idx, bit first, bit last);
		in_word_t w;
		w.op = OP_FRAME;
		w.sample_left = rand_sample();
		w.sample_right = rand_sample();
		w.frame_index = idx;
		w.block_first = first;
		w.block_last = last;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_start();
		in_word_t w;
		w = make_frame(FRAME_W'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
		w.op = OP_START;
		send_word(w);
		need_seed = 1'b1;
		open_aligned = 1'b0;
	endtask

	task automatic send_request(int len, bit aligned, bit with_last);
		logic [FRAME_W-1:0] start;
		if (need_seed || !aligned)
			start = FRAME_W'($urandom());
		else
			start = ring_pos;
		if (need_seed) begin
			ring_pos = start;
			need_seed = 1'b0;
		end
		for (int i = 0; i < len; i++)
			send_word(make_frame(FRAME_W'(start + i), i == 0, with_last && i == len - 1));
		if (with_last && start == ring_pos)
			ring_pos = FRAME_W'(start + len);
		open_aligned = !with_last && start == ring_pos;
	endtask

	task automatic send_random_unit();
		logic [FRAME_W-1:0] idx;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_request($urandom_range(1, 6), $urandom_range(99) < 85, 1'b1);
		end else if (pick < 78) begin
			send_start();
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 3))
				send_word(make_frame(FRAME_W'($urandom()), 1'b0, 1'b0));
		end else if (pick < 95) begin
			send_request($urandom_range(1, 4), 1'($urandom_range(1)), 1'b0);
		end else begin
			idx = FRAME_W'($urandom());
			send_word(make_frame(idx, 1'b0, 1'b1));
			if (open_aligned)
				ring_pos = idx + 1'b1;
			open_aligned = 1'b0;
		end
	endtask

	// wait until every expected word is out and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filt_model.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [DB_W-1:0] db);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= db;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		filt_model.gain_db = db;
	endtask

	initial begin
		in_word_t        w;
		logic [DB_W-1:0] seg_gain[6];
		int              target;
		bit              hold_done;

		hold_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frame outside any request, at reset gain
		w = make_frame(14'd7, 1'b0, 1'b0);
		w.sample_left = S_MAX;
		w.sample_right = S_MIN;
		send_word(w);
		send_start();

		// seeded request across the ring wrap, commits
		w = make_frame(14'd16382, 1'b1, 1'b0);
		w.sample_left = S_MAX;
		w.sample_right = S_MIN;
		send_word(w);
		w = make_frame(14'd16383, 1'b0, 1'b0);
		w.sample_left = S_MIN;
		w.sample_right = S_MAX;
		send_word(w);
		w = make_frame(14'd0, 1'b0, 1'b1);
		w.sample_left = '0;
		w.sample_right = '1;
		send_word(w);
		need_seed = 1'b0;
		ring_pos = 14'd1;

		// DC step, contiguous
		for (int i = 0; i < 6; i++) begin
			w = make_frame(FRAME_W'(i + 1), i == 0, i == 5);
			w.sample_left = 32'sh2000_0000;
			w.sample_right = -32'sh2000_0000;
			send_word(w);
		end
		ring_pos = 14'd7;

		send_request(2, 1'b0, 1'b1);
		send_request(1, 1'b1, 1'b1);
		send_word(make_frame(ring_pos, 1'b0, 1'b1));
		send_start();
		send_request(2, 1'b1, 1'b1);

		seg_gain[0] = 6'd0;
		seg_gain[1] = 6'd63;
		seg_gain[2] = DB_W'(MAX_DB);
		seg_gain[3] = DB_W'($urandom_range(1, 39));
		seg_gain[4] = 6'd17;
		seg_gain[5] = DB_W'($urandom_range(0, 63));

		for (int seg = 0; seg < 6; seg++) begin
			write_gain(seg_gain[seg]);
			case (seg / 2)
				0: begin
					send_idle_pct = 37;
					recv_stall_pct <= 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct <= 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
			endcase
			target = items_sent + SEG_ITEMS;
			while (items_sent < target) begin
				if (seg == 4 && !hold_done && items_sent >= target - SEG_ITEMS + 10) begin
					hold_req <= hold_req + 1;
					hold_done = 1'b1;
				end
				send_random_unit();
			end
		end

		drain();
		if (filt_model.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/sdbgc_pkg.sv
rtl/core/sdbgc_ctrl.sv
rtl/core/sdbgc_dp.sv
rtl/core/stereo_dc_block_gain_clip.sv
verif/tb_top.sv
